/* rtl/core/vfde_pkg.sv */
package vfde_pkg;

  localparam int FRAME_BYTES_DEFAULT = 262144;
  localparam int Q_DEPTH = 4;

  localparam logic [1:0] OP_PLOT = 2'd0;
  localparam logic [1:0] OP_FILL = 2'd1;
  localparam logic [1:0] OP_BLIT = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  localparam int LIN_W = 320;
  localparam int LIN_H = 200;
  localparam int PL_W = 640;
  localparam int PL_H = 480;
  localparam int PLANE_BYTES = (640 * 480) / 8;
  localparam int ROW_BYTES = 640 / 8;
  localparam logic [7:0] LEFT_MASK = 8'h80;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  x;
    logic [8:0]  y;
    logic [9:0]  w;
    logic [8:0]  h;
    logic [7:0]  color;
    logic [7:0]  pattern;
    logic [17:0] addr;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  function automatic logic [17:0] plane_base(input logic [1:0] p);
    logic [17:0] b;
    case (p)
      2'd0:    b = 18'd0;
      2'd1:    b = 18'(PLANE_BYTES);
      2'd2:    b = 18'(2 * PLANE_BYTES);
      default: b = 18'(3 * PLANE_BYTES);
    endcase
    return b;
  endfunction

endpackage

/* rtl/core/vfde_cmd_if.sv */
interface vfde_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [9:0]  pos_x;
  logic [8:0]  pos_y;
  logic [9:0]  rect_width;
  logic [8:0]  rect_height;
  logic [7:0]  pixel_color;
  logic [7:0]  pattern;
  logic [17:0] byte_address;

  modport source (output valid, op, pos_x, pos_y, rect_width, rect_height, pixel_color,
                  pattern, byte_address, input ready);
  modport sink (input valid, op, pos_x, pos_y, rect_width, rect_height, pixel_color,
                pattern, byte_address, output ready);
endinterface

/* rtl/core/vfde_rsp_if.sv */
interface vfde_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

/* rtl/core/vfde_ram.sv */
module vfde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/vfde_front.sv */
module vfde_front (
  input  logic             clk,
  input  logic             rst,
  vfde_cmd_if.sink         cmd,
  output vfde_pkg::q_head_t head,
  input  logic             pop
);
  localparam int QW = $clog2(vfde_pkg::Q_DEPTH);

  vfde_pkg::cmd_t q [vfde_pkg::Q_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0]   count;
  vfde_pkg::cmd_t decoded;
  logic push;

  always_comb begin
    decoded.op      = cmd.op;
    decoded.x       = cmd.pos_x;
    decoded.y       = cmd.pos_y;
    decoded.color   = cmd.pixel_color;
    decoded.pattern = cmd.pattern;
    decoded.addr    = cmd.byte_address;
    unique case (cmd.op)
      vfde_pkg::OP_PLOT: begin
        decoded.w = 10'd1;
        decoded.h = 9'd1;
      end
      vfde_pkg::OP_BLIT: begin
        decoded.w = 10'd8;
        decoded.h = 9'd1;
      end
      default: begin
        decoded.w = cmd.rect_width;
        decoded.h = cmd.rect_height;
      end
    endcase
  end

  assign cmd.ready  = (count != (QW+1)'(vfde_pkg::Q_DEPTH));
  assign push       = cmd.valid && cmd.ready;
  assign head.valid = (count != '0);
  assign head.cmd   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= decoded;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QW+1)'(push) - (QW+1)'(pop);
    end
  end
endmodule

/* rtl/core/vfde_back.sv */
module vfde_back #(
  parameter int FRAME_BYTES = vfde_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              display_mode,
  input  vfde_pkg::q_head_t head,
  output logic              pop,
  vfde_rsp_if.source        rsp
);
  localparam int AW = $clog2(FRAME_BYTES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PIX   = 3'd1;
  localparam logic [2:0] S_PRD   = 3'd2;
  localparam logic [2:0] S_PWR   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_RDATA = 3'd5;

  logic [2:0] state, state_next;
  vfde_pkg::cmd_t cur;
  logic [8:0] fill_row, fill_row_next;
  logic [9:0] fill_column, fill_column_next;
  logic [1:0] plane, plane_next;
  logic       in_range;

  logic [9:0]  yy;
  logic [10:0] xx;
  logic [10:0] sw;
  logic [9:0]  sh;
  logic        draw;
  logic [17:0] lin_addr, pl_addr;
  logic [7:0]  mask;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  vfde_ram #(.WIDTH(8), .DEPTH(FRAME_BYTES)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  always_comb begin
    yy   = 10'(cur.y) + 10'(fill_row);
    xx   = 11'(cur.x) + 11'(fill_column);
    sw   = display_mode ? 11'(vfde_pkg::PL_W) : 11'(vfde_pkg::LIN_W);
    sh   = display_mode ? 10'(vfde_pkg::PL_H) : 10'(vfde_pkg::LIN_H);
    draw = (cur.op != vfde_pkg::OP_BLIT) || cur.pattern[~fill_column[2:0]];
    // y*320 and y*80 as shift-and-add
    lin_addr = (18'(yy[7:0]) << 8) + (18'(yy[7:0]) << 6) + 18'(xx[8:0]);
    pl_addr  = (18'(yy[8:0]) << 6) + (18'(yy[8:0]) << 4) + 18'(xx[9:3])
             + vfde_pkg::plane_base(plane);
    mask = vfde_pkg::LEFT_MASK >> xx[2:0];
  end

  always_comb begin
    state_next       = state;
    fill_row_next    = fill_row;
    fill_column_next = fill_column;
    plane_next       = plane;
    pop   = 1'b0;
    we    = 1'b0;
    waddr = AW'(lin_addr);
    wdata = cur.color;
    raddr = AW'(pl_addr);
    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          fill_row_next    = '0;
          fill_column_next = '0;
          state_next = (head.cmd.op == vfde_pkg::OP_READ) ? S_READ : S_PIX;
        end
      end
      S_PIX: begin
        if (fill_row >= cur.h || yy >= sh) begin
          fill_row_next    = '0;
          fill_column_next = '0;
          state_next = S_IDLE;
        end else if (fill_column >= cur.w || xx >= sw) begin
          fill_row_next    = fill_row + 1'b1;
          fill_column_next = '0;
        end else if (draw && display_mode) begin
          plane_next = '0;
          state_next = S_PRD;
        end else begin
          we = draw;
          fill_column_next = fill_column + 1'b1;
        end
      end
      S_PRD: begin
        state_next = S_PWR;
      end
      S_PWR: begin
        we    = 1'b1;
        waddr = AW'(pl_addr);
        wdata = cur.color[plane] ? (rdata | mask) : (rdata & ~mask);
        plane_next = plane + 1'b1;
        if (plane == 2'd3) begin
          fill_column_next = fill_column + 1'b1;
          state_next = S_PIX;
        end else begin
          state_next = S_PRD;
        end
      end
      S_READ: begin
        raddr = AW'(cur.addr);
        if (!rsp.valid) state_next = S_RDATA;
      end
      S_RDATA: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head.cmd;
    if (state == S_READ) begin
      in_range <= (AW+1)'(cur.addr) < (AW+1)'(FRAME_BYTES);
    end
    if (state == S_RDATA) begin
      rsp.read_data <= in_range ? rdata : 8'd0;
    end
    if (rst) begin
      state       <= S_IDLE;
      fill_row    <= '0;
      fill_column <= '0;
      plane       <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      state       <= state_next;
      fill_row    <= fill_row_next;
      fill_column <= fill_column_next;
      plane       <= plane_next;
      if (state == S_RDATA)    rsp.valid <= 1'b1;
      else if (rsp.ready)      rsp.valid <= 1'b0;
    end
  end
endmodule

/* rtl/core/vga_framebuffer_draw_engine.sv */
// Draw engine over a byte frame store, in 320x200 linear or 640x480 four-plane mode.
// Commands enter a four-deep queue and run one at a time on a sequencer that owns the
// frame store. In linear mode a plot, blit or fill pixel is written directly; in planar
// mode each drawn pixel is picked, then each of the four planes is read and written
// back in turn. A blit pixel whose pattern bit is clear is stepped over without a write.
// Every row of a plot, blit or fill ends with a step to the next row, whether it ends
// at the width or at the screen edge, and a closing step ends the command. A read
// returns its byte in an output register, so draws keep going while it waits; a
// following read stalls until that byte is taken. Each command is dispatched from the
// idle state. The frame store is not cleared: read only bytes that were drawn.
module vga_framebuffer_draw_engine #(
  parameter int FRAME_BYTES = vfde_pkg::FRAME_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_enable,
  input  logic       cfg_write_data,
  vfde_cmd_if.sink   cmd,
  vfde_rsp_if.source rsp
);
  logic              display_mode;
  vfde_pkg::q_head_t head;
  logic              pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      display_mode <= 1'b0;
    end else if (cfg_write_enable) begin
      display_mode <= cfg_write_data;
    end
  end

  vfde_front u_front (
    .clk, .rst, .cmd, .head, .pop
  );

  vfde_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk, .rst, .display_mode, .head, .pop, .rsp
  );
endmodule
